// File: hw/rtl/wsrf_pkg.sv
package wsrf_pkg;

  localparam int unsigned SPEED_W = 14;
  localparam int unsigned RELOAD_W = 8;

  localparam logic [SPEED_W-1:0] SPEED_MAX = 14'd9600;
  localparam logic [RELOAD_W-1:0] RELOAD_RST = 8'd5;

  // band edges in 1/64 m/s: 40, 60, 80, 100 m/s
  localparam logic [SPEED_W-1:0] EDGE_0 = 14'd2560;
  localparam logic [SPEED_W-1:0] EDGE_1 = 14'd3840;
  localparam logic [SPEED_W-1:0] EDGE_2 = 14'd5120;
  localparam logic [SPEED_W-1:0] EDGE_3 = 14'd6400;

  // allowed jumps: 30, 25, 20, 15, 10 m/s
  localparam logic [SPEED_W-1:0] GAP_0 = 14'd1920;
  localparam logic [SPEED_W-1:0] GAP_1 = 14'd1600;
  localparam logic [SPEED_W-1:0] GAP_2 = 14'd1280;
  localparam logic [SPEED_W-1:0] GAP_3 = 14'd960;
  localparam logic [SPEED_W-1:0] GAP_4 = 14'd640;

  localparam int unsigned ADDR_W = 2;
  localparam logic [ADDR_W-1:0] ADDR_HOLDOFF = 2'd0;

  // sample moving from the input register into the decision stage
  typedef struct packed {
    logic               take;
    logic signed [15:0] speed;
  } wsrf_stage_t;

  function automatic logic [SPEED_W-1:0] allowed_gap(input logic [SPEED_W-1:0] s);
    logic [SPEED_W-1:0] g;
    if (s < EDGE_0) g = GAP_0;
    else if (s < EDGE_1) g = GAP_1;
    else if (s < EDGE_2) g = GAP_2;
    else if (s < EDGE_3) g = GAP_3;
    else g = GAP_4;
    return g;
  endfunction

endpackage

// File: hw/rtl/wsrf_cfg.sv
module wsrf_cfg
  import wsrf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output logic [RELOAD_W-1:0] holdoff_reload
);

  logic [RELOAD_W-1:0] reload_r;
  logic [RELOAD_W-1:0] reload_nxt;
  logic                wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    reload_nxt = reload_r;
    if (wr_en && (cfg_paddr == ADDR_HOLDOFF)) begin
      reload_nxt = cfg_pwdata[RELOAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= RELOAD_RST;
    end else begin
      reload_r <= reload_nxt;
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      ADDR_HOLDOFF: cfg_prdata = {{(32-RELOAD_W){1'b0}}, reload_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  assign holdoff_reload = reload_r;

endmodule

// File: hw/rtl/wsrf_core.sv
module wsrf_core
  import wsrf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  wsrf_stage_t         stage,
  input  logic [RELOAD_W-1:0] holdoff_reload,
  input  logic                out_stall,
  output logic                out_valid,
  output logic                out_accepted,
  output logic [SPEED_W-1:0]  out_reference_speed
);

  logic [SPEED_W-1:0]  ref_r, ref_nxt;
  logic                ref_ok_r, ref_ok_nxt;
  logic [RELOAD_W-1:0] ctr_r, ctr_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic                oacc_r, oacc_nxt;
  logic [SPEED_W-1:0]  oref_r;

  logic               in_range;
  logic [SPEED_W-1:0] s;
  logic [SPEED_W-1:0] jump;
  logic               jump_ok;

  assign s = stage.speed[SPEED_W-1:0];
  // not negative and at most 150 m/s
  assign in_range = !stage.speed[15] && (stage.speed[14:0] <= {1'b0, SPEED_MAX});
  assign jump = (s >= ref_r) ? (s - ref_r) : (ref_r - s);
  assign jump_ok = jump <= allowed_gap(s);

  always_comb begin
    ref_nxt    = ref_r;
    ref_ok_nxt = ref_ok_r;
    ctr_nxt    = ctr_r;
    oacc_nxt   = 1'b0;
    if (stage.take && in_range) begin
      if (!ref_ok_r) begin
        ref_nxt    = s;
        ref_ok_nxt = 1'b1;
        oacc_nxt   = 1'b1;
      end else if (jump_ok) begin
        ref_nxt  = s;
        ctr_nxt  = holdoff_reload;
        oacc_nxt = 1'b1;
      end else if (ctr_r == '0) begin
        // holdoff spent: resync to the sample but still reject it
        ref_nxt = s;
        ctr_nxt = holdoff_reload;
      end else begin
        ctr_nxt = ctr_r - 1'b1;
      end
    end
  end

  always_comb begin
    if (stage.take) ovalid_nxt = 1'b1;
    else if (!out_stall) ovalid_nxt = 1'b0;
    else ovalid_nxt = ovalid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r    <= '0;
      ref_ok_r <= 1'b0;
      ctr_r    <= RELOAD_RST;
      ovalid_r <= 1'b0;
    end else begin
      ref_r    <= ref_nxt;
      ref_ok_r <= ref_ok_nxt;
      ctr_r    <= ctr_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage.take) begin
      oacc_r <= oacc_nxt;
      oref_r <= ref_nxt;
    end
  end

  assign out_valid           = ovalid_r;
  assign out_accepted        = oacc_r;
  assign out_reference_speed = oref_r;

`ifndef ASSERT_OFF
  a_ref_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (oref_r <= SPEED_MAX))
    else $error("reference beyond 150 m/s");

  a_ctr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !stage.take |=> $stable(ctr_r) && $stable(ref_r))
    else $error("filter state moved without a sample");

  a_ref_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && oacc_r |-> ref_ok_r)
    else $error("accepted sample left no reference");

  a_take_room: assert property (@(posedge clk) disable iff (!rst_n)
    stage.take |-> (!ovalid_r || !out_stall))
    else $error("result register overwritten while stalled");
`endif

endmodule

// File: hw/rtl/wind_spike_rejection_filter.sv
// Channel  Direction  Ports                                        Transfer
// in       input      in_valid, in_stall, in_wind_speed            valid & !stall
// out      output     out_valid, out_stall, out_accepted,          valid & !stall
//                     out_reference_speed
// cfg      APB slave  cfg_psel/penable/pwrite/paddr/pwdata/        psel & penable &
//                     prdata/pready                                pwrite & pready
//
// One sample per cycle sustained while out_stall stays low; each sample passes
// through the input register, then the decision into the result register.
// The filter state updates as the sample leaves the input register, so the
// next sample sees it at once.
// Reset (rst_n low, synchronous) clears both stages, drops the reference and
// loads the holdoff counter and holdoff_reload with 5.
// A stalled result holds in the result register while one more sample waits
// in the input register; in_stall rises only when both are full.
module wind_spike_rejection_filter
  import wsrf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_wind_speed,

  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_accepted,
  output logic [SPEED_W-1:0] out_reference_speed,

  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  logic                s1_valid_r;
  logic                s1_valid_nxt;
  logic signed [15:0]  s1_speed_r;
  logic                advance;
  wsrf_stage_t         stage;
  logic [RELOAD_W-1:0] holdoff_reload;

  // Advance the held sample whenever the result register is free or draining.
  assign advance  = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Capture the payload on every open cycle; hold it while stalled.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_speed_r <= in_wind_speed;
    end
  end

  assign stage.take  = advance;
  assign stage.speed = s1_speed_r;

  wsrf_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .holdoff_reload (holdoff_reload)
  );

  wsrf_core u_core (
    .clk                 (clk),
    .rst_n               (rst_n),
    .stage               (stage),
    .holdoff_reload      (holdoff_reload),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_accepted        (out_accepted),
    .out_reference_speed (out_reference_speed)
  );

`ifndef ASSERT_OFF
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid)
    else $error("input stalled with room in the pipe");

  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("advanced sample produced no result");

  a_held_sample: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> s1_valid_r && $stable(s1_speed_r))
    else $error("held sample lost under stall");
`endif

endmodule
